// ===== sv/sqte_pkg.sv =====
// Shared definitions for the stack and queue transfer engine.
// Holds operation and status codes, the result record and parameter defaults.
// No dependencies.
`default_nettype none

package sqte_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // Operation codes carried by the mode field.
    localparam logic [2:0] MODE_PUSH     = 3'd0;
    localparam logic [2:0] MODE_POP      = 3'd1;
    localparam logic [2:0] MODE_ENQUEUE  = 3'd2;
    localparam logic [2:0] MODE_DEQUEUE  = 3'd3;
    localparam logic [2:0] MODE_STK2QUE  = 3'd4;
    localparam logic [2:0] MODE_QUE2STK  = 3'd5;

    // Status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic [1:0]         status;
        logic [4:0]         moved_count;
        logic [4:0]         stack_level;
        logic [4:0]         queue_level;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/sqte_ram.sv =====
// Simple dual-port memory: one write port, one read port, registered read data.
// Depends on sqte_pkg for its default sizes.
`default_nettype none

module sqte_ram #(
    parameter int DEPTH      = sqte_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = sqte_pkg::DATA_WIDTH_DEFAULT,
    localparam int ADDR_W    = $clog2(DEPTH)
) (
    input  wire logic                  aclk,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_W-1:0]     wr_addr,
    input  wire logic [DATA_WIDTH-1:0] wr_data,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_W-1:0]     rd_addr,
    output logic      [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/stack_queue_transfer_engine.sv =====
// Top level of the stack and queue transfer engine: control, pointers and result path.
// Depends on sqte_pkg and instantiates sqte_ram for the stack and the queue stores.
//
//   channel | direction | ports                                         | handshake
//   s_      | in        | s_mode, s_data_in                             | s_valid / s_ready
//   m_      | out       | m_data_out, m_status, m_moved_count,          | m_valid / m_ready
//           |           | m_stack_level, m_queue_level                  |
//
// Push, enqueue and any operation that only reports a status load their result in the cycle they are accepted.
// Pop and dequeue read the store first and load their result in the read state, as the store's read data is registered.
// A move reads one element per cycle and writes each in the cycle after its read; the result loads with the last write.
// Reset clears the levels and the queue pointers; the stores themselves are not cleared.
// A stalled result waits in an output register with one staging entry behind it.
`default_nettype none

module stack_queue_transfer_engine #(
    parameter int DEPTH      = sqte_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = sqte_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_mode,
    input  wire logic signed [31:0] s_data_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_data_out,
    output logic [1:0]              m_status,
    output logic [4:0]              m_moved_count,
    output logic [4:0]              m_stack_level,
    output logic [4:0]              m_queue_level
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [FILL_W-1:0] FULL_LVL = FILL_W'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_MOVE = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [FILL_W-1:0]       sf_reg, sf_next;
    logic [FILL_W-1:0]       qf_reg, qf_next;
    logic [ADDR_W-1:0]       qh_reg, qh_next;
    logic [ADDR_W-1:0]       qt_reg, qt_next;
    logic                    src_q_reg, src_q_next;
    logic [FILL_W-1:0]       rd_left_reg, rd_left_next;
    logic [FILL_W-1:0]       moved_reg, moved_next;
    logic                    pend_reg, pend_next;
    sqte_pkg::result_t       res_reg, res_new;
    logic                    res_valid_reg, res_valid_next;
    sqte_pkg::result_t       out_reg;
    logic                    m_valid_reg;

    logic                    s_fire, res_go, res_load;
    logic                    stk_we, stk_re, q_we, q_re;
    logic [DATA_WIDTH-1:0]   wr_value, stk_wdata, q_wdata, stk_rdata, q_rdata;
    logic [FILL_W-1:0]       stk_top, q_space, move_n;
    logic signed [31:0]      dout;
    logic [1:0]              status;

    // The input is sign-extended or truncated to the storage width.
    assign wr_value = DATA_WIDTH'(s_data_in);

    assign res_go  = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE) && (!res_valid_reg || res_go);
    assign s_fire  = s_valid && s_ready;

    assign stk_top = sf_reg - FILL_W'(1);
    assign q_space = FULL_LVL - qf_reg;
    assign move_n  = (sf_reg < q_space) ? sf_reg : q_space;

    sqte_ram #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_we),
        .wr_addr (sf_reg[ADDR_W-1:0]),
        .wr_data (stk_wdata),
        .rd_en   (stk_re),
        .rd_addr (stk_top[ADDR_W-1:0]),
        .rd_data (stk_rdata)
    );

    sqte_ram #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_queue_ram (
        .aclk    (aclk),
        .wr_en   (q_we),
        .wr_addr (qt_reg),
        .wr_data (q_wdata),
        .rd_en   (q_re),
        .rd_addr (qh_reg),
        .rd_data (q_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        sf_next      = sf_reg;
        qf_next      = qf_reg;
        qh_next      = qh_reg;
        qt_next      = qt_reg;
        src_q_next   = src_q_reg;
        rd_left_next = rd_left_reg;
        moved_next   = moved_reg;
        pend_next    = pend_reg;
        stk_we       = 1'b0;
        stk_re       = 1'b0;
        q_we         = 1'b0;
        q_re         = 1'b0;
        stk_wdata    = wr_value;
        q_wdata      = wr_value;
        res_load     = 1'b0;
        dout         = '0;
        status       = sqte_pkg::STATUS_OK;

        unique case (state_reg)
            ST_IDLE: begin
                moved_next = '0;
                if (s_fire) begin
                    unique case (s_mode)
                        sqte_pkg::MODE_PUSH: begin
                            res_load = 1'b1;
                            if (sf_reg == FULL_LVL) begin
                                status = sqte_pkg::STATUS_FULL;
                            end else begin
                                stk_we  = 1'b1;
                                sf_next = sf_reg + FILL_W'(1);
                            end
                        end
                        sqte_pkg::MODE_POP: begin
                            if (sf_reg == '0) begin
                                res_load = 1'b1;
                                dout     = sqte_pkg::EMPTY_VALUE;
                                status   = sqte_pkg::STATUS_EMPTY;
                            end else begin
                                stk_re     = 1'b1;
                                sf_next    = stk_top;
                                src_q_next = 1'b0;
                                state_next = ST_READ;
                            end
                        end
                        sqte_pkg::MODE_ENQUEUE: begin
                            res_load = 1'b1;
                            if (qf_reg == FULL_LVL) begin
                                status = sqte_pkg::STATUS_FULL;
                            end else begin
                                q_we    = 1'b1;
                                qt_next = (qt_reg == LAST_IDX) ? '0 : qt_reg + ADDR_W'(1);
                                qf_next = qf_reg + FILL_W'(1);
                            end
                        end
                        sqte_pkg::MODE_DEQUEUE: begin
                            if (qf_reg == '0) begin
                                res_load = 1'b1;
                                dout     = sqte_pkg::EMPTY_VALUE;
                                status   = sqte_pkg::STATUS_EMPTY;
                            end else begin
                                q_re       = 1'b1;
                                qh_next    = (qh_reg == LAST_IDX) ? '0 : qh_reg + ADDR_W'(1);
                                qf_next    = qf_reg - FILL_W'(1);
                                src_q_next = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        sqte_pkg::MODE_STK2QUE: begin
                            if (sf_reg == '0) begin
                                res_load = 1'b1;
                                status   = sqte_pkg::STATUS_EMPTY;
                            end else if (qf_reg == FULL_LVL) begin
                                res_load = 1'b1;
                                status   = sqte_pkg::STATUS_FULL;
                            end else begin
                                rd_left_next = move_n;
                                moved_next   = move_n;
                                pend_next    = 1'b0;
                                src_q_next   = 1'b0;
                                state_next   = ST_MOVE;
                            end
                        end
                        sqte_pkg::MODE_QUE2STK: begin
                            if (qf_reg == '0) begin
                                res_load = 1'b1;
                                status   = sqte_pkg::STATUS_EMPTY;
                            end else if (sf_reg == FULL_LVL) begin
                                res_load = 1'b1;
                                status   = sqte_pkg::STATUS_FULL;
                            end else begin
                                // Space on the stack bounds the move as tightly as the queue fill.
                                rd_left_next = (qf_reg < FULL_LVL - sf_reg) ?
                                               qf_reg : FULL_LVL - sf_reg;
                                moved_next   = rd_left_next;
                                pend_next    = 1'b0;
                                src_q_next   = 1'b1;
                                state_next   = ST_MOVE;
                            end
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_load   = 1'b1;
                dout       = src_q_reg ? 32'(q_rdata) : 32'(stk_rdata);
                state_next = ST_IDLE;
            end
            ST_MOVE: begin
                // The element read in the previous cycle is written to the destination.
                if (pend_reg) begin
                    if (src_q_reg) begin
                        stk_we    = 1'b1;
                        stk_wdata = q_rdata;
                        sf_next   = sf_reg + FILL_W'(1);
                    end else begin
                        q_we    = 1'b1;
                        q_wdata = stk_rdata;
                        qt_next = (qt_reg == LAST_IDX) ? '0 : qt_reg + ADDR_W'(1);
                        qf_next = qf_reg + FILL_W'(1);
                    end
                end
                if (rd_left_reg != '0) begin
                    rd_left_next = rd_left_reg - FILL_W'(1);
                    pend_next    = 1'b1;
                    if (src_q_reg) begin
                        q_re    = 1'b1;
                        qh_next = (qh_reg == LAST_IDX) ? '0 : qh_reg + ADDR_W'(1);
                        qf_next = qf_reg - FILL_W'(1);
                    end else begin
                        stk_re  = 1'b1;
                        sf_next = stk_top;
                    end
                end else begin
                    pend_next  = 1'b0;
                    moved_next = '0;
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        res_new.data_out    = dout;
        res_new.status      = status;
        res_new.moved_count = 5'(moved_reg);
        res_new.stack_level = 5'(sf_next);
        res_new.queue_level = 5'(qf_next);
    end

    always_comb begin
        if (res_load) begin
            res_valid_next = 1'b1;
        end else if (res_go) begin
            res_valid_next = 1'b0;
        end else begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sf_reg        <= '0;
            qf_reg        <= '0;
            qh_reg        <= '0;
            qt_reg        <= '0;
            rd_left_reg   <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sf_reg        <= sf_next;
            qf_reg        <= qf_next;
            qh_reg        <= qh_next;
            qt_reg        <= qt_next;
            rd_left_reg   <= rd_left_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
            if (res_valid_reg && res_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        src_q_reg <= src_q_next;
        moved_reg <= moved_next;
        if (res_load) begin
            res_reg <= res_new;
        end
        if (res_valid_reg && res_go) begin
            out_reg <= res_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data_out    = out_reg.data_out;
    assign m_status      = out_reg.status;
    assign m_moved_count = out_reg.moved_count;
    assign m_stack_level = out_reg.stack_level;
    assign m_queue_level = out_reg.queue_level;

`ifndef SYNTH
    logic [FILL_W:0] move_total;
    assign move_total = (FILL_W+1)'(sf_reg) + (FILL_W+1)'(qf_reg) + (FILL_W+1)'(pend_reg);

    // An element in flight during a move is neither lost nor duplicated.
    a_move_conserves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOVE) |=> (move_total == $past(move_total)))
        else $error("element count changed during a move");

    a_no_stack_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_we |-> (sf_reg != FULL_LVL))
        else $error("stack written while full");

    a_no_queue_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_we |-> (qf_reg != FULL_LVL))
        else $error("queue written while full");

    a_staged_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg |-> (state_reg == ST_IDLE))
        else $error("staged result while an operation is still running");

    a_pop_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_mode == sqte_pkg::MODE_POP) && (sf_reg != '0))
        |=> (state_reg == ST_READ))
        else $error("pop of a non-empty stack did not wait for read data");
`endif

endmodule

`default_nettype wire
